FILE: hdl/sacm_pkg.sv
// Shared types, constants and helpers for the set-associative cache model.
// No dependencies; every other file but sacm_ram imports this package.
package sacm_pkg;

    localparam int MAX_SETS  = 256;
    localparam int MAX_WAYS  = 8;
    localparam int ADDR_BITS = 32;

    localparam int SIB_MAX = $clog2(MAX_SETS);
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int TAG_W   = ADDR_BITS;
    localparam int STAMP_W = 48;
    localparam int CNT_W   = 32;
    localparam int ADD_W   = 19;
    localparam int LFSR_W  = 16;
    localparam int CFG_W   = 4;
    localparam int CIDX_W  = 3;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [ADD_W-1:0]  BASE_COST = 19'd100;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_SET_BITS  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_WAYS      = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_BLOCK     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_WALLOC    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_WTHROUGH  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_POLICY    = 3'd5;

    localparam logic [1:0] RP_LRU    = 2'd0;
    localparam logic [1:0] RP_FIFO   = 2'd1;
    localparam logic [1:0] RP_RANDOM = 2'd2;

    typedef struct packed {
        logic [MAX_WAYS-1:0]              valid;
        logic [MAX_WAYS-1:0]              dirty;
        logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
        logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic              start;
        logic [LFSR_W-1:0] dividend;
        logic [WCNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [WAY_W-1:0] rem;
    } mod_rsp_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
        logic b;
        b = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {b, l[LFSR_W-1:1]};
    endfunction

endpackage

FILE: hdl/sacm_ifs.sv
// Valid/ready channel interfaces for access requests and results.
// Depends on sacm_pkg.
interface sacm_req_if import sacm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [ADDR_BITS-1:0] address;
    modport source (output valid, kind, address, input ready);
    modport sink   (input valid, kind, address, output ready);
endinterface

interface sacm_rsp_if import sacm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic               wrote_back;
    logic [ADD_W-1:0]   cycles_added;
    logic [STAMP_W-1:0] total_cycles;
    logic [CNT_W-1:0]   load_hits;
    logic [CNT_W-1:0]   load_misses;
    logic [CNT_W-1:0]   store_hits;
    logic [CNT_W-1:0]   store_misses;
    modport source (output valid, hit, wrote_back, cycles_added, total_cycles,
                    load_hits, load_misses, store_hits, store_misses, input ready);
    modport sink   (input valid, hit, wrote_back, cycles_added, total_cycles,
                    load_hits, load_misses, store_hits, store_misses, output ready);
endinterface

FILE: hdl/set_assoc_cache_model_core.sv
// Set-associative cache model core: config registers, set RAM, lookup and update.
// Depends on sacm_pkg, sacm_ifs, sacm_ram, sacm_mod.
//
// Usage: configure through cfg_we/cfg_index/cfg_data while idle, then send
// accesses (kind, address) on req; each one yields exactly one result beat on
// rsp with hit, write-back flag, cost and running saturating counters.
// One set row (all ways) lives in a RAM word; an access reads the row while
// the request is taken, compares the tags of the ways in use and picks a victim in the next
// cycle, then writes the row back and loads the result register.
// A new request is taken only in idle, after the row of the last one is written back.
// A random-policy eviction among all-valid ways also waits in ST_MODW for the
// bit-serial remainder.
// The result register loads together with the row write-back, from ST_LOOK or,
// for the random eviction case, from ST_MODW.
// Reset: counters and total clear, LFSR seeds, every set reads as empty via a
// per-set flag; no clearing sweep is needed.
// A stalled rsp holds its beat; one more request is taken meanwhile and waits
// in lookup until the result register frees up.
module set_assoc_cache_model_core import sacm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    sacm_req_if.sink          req,
    sacm_rsp_if.source        rsp
);
    localparam logic [STAMP_W-1:0] TOT_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX = '1;

    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_MODW} state_t;

    typedef struct packed {
        logic             en;
        logic [STAMP_W-1:0] stamp;
        logic [WAY_W-1:0] idx;
    } cand_t;

    // configuration
    logic [CFG_W-1:0] sib_cfg_reg, ways_cfg_reg, bs_cfg_reg;
    logic             walloc_reg, wthru_reg;
    logic [1:0]       policy_reg;

    logic [CFG_W-1:0]  sib_eff, bs_eff;
    logic [WCNT_W-1:0] ways_eff;
    logic [ADD_W-1:0]  penalty;

    state_t             state_reg;
    logic               kind_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [SET_W-1:0]   set_reg;
    logic [MAX_SETS-1:0] row_init_reg;
    logic [LFSR_W-1:0]  lfsr_reg;
    logic [STAMP_W-1:0] total_reg;
    logic [CNT_W-1:0]   lh_reg, lm_reg, sh_reg, sm_reg;

    logic               out_valid_reg, out_hit_reg, out_wb_reg;
    logic [ADD_W-1:0]   out_added_reg;

    logic [SET_W-1:0]   set_in;
    logic [TAG_W-1:0]   tag_in;
    logic [SET_W-1:0]   raddr;
    logic [ROW_W-1:0]   rdata;
    row_t               rd, wr;
    logic               we;

    mod_req_t mreq;
    mod_rsp_t mrsp;

    // config clamping
    always_comb
    begin
        bs_eff = (bs_cfg_reg < 4'd2) ? 4'd2 : ((bs_cfg_reg > 4'd12) ? 4'd12 : bs_cfg_reg);
        sib_eff = (sib_cfg_reg > CFG_W'(SIB_MAX)) ? CFG_W'(SIB_MAX) : sib_cfg_reg;
        if (ways_cfg_reg == '0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if ({1'b0, ways_cfg_reg} > 5'(MAX_WAYS))
        begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCNT_W'(ways_cfg_reg);
        end
        penalty = BASE_COST << (bs_eff - 4'd2);
    end

    // address split
    logic [ADDR_BITS-1:0] set_mask;
    logic [CFG_W:0]       tsh;
    always_comb
    begin
        set_mask = (ADDR_BITS'(1) << sib_eff) - ADDR_BITS'(1);
        set_in   = SET_W'((req.address >> bs_eff) & set_mask);
        tsh      = {1'b0, bs_eff} + {1'b0, sib_eff};
        if (32'(tsh) >= ADDR_BITS)
        begin
            tag_in = '0;
        end
        else
        begin
            tag_in = TAG_W'(req.address >> tsh);
        end
    end

    assign raddr = (state_reg == ST_IDLE) ? set_in : set_reg;

    sacm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (set_reg),
        .wdata (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd = row_t'(rdata);

    // lookup
    logic [MAX_WAYS-1:0] vld, dty, way_en;
    logic                hit, inv_found, fill, need_rand, wb, out_free, commit;
    logic [WAY_W-1:0]    hit_idx, inv_idx, lru_idx, victim;
    logic [ADD_W-1:0]    added;
    logic [STAMP_W:0]    sum;
    logic [STAMP_W-1:0]  new_total;
    cand_t               lvl [2*MAX_WAYS-1];

    always_comb
    begin
        vld = rd.valid & {MAX_WAYS{row_init_reg[set_reg]}};
        dty = rd.dirty & vld;
        hit = 1'b0;
        hit_idx = '0;
        inv_found = 1'b0;
        inv_idx = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_en[w] = (w < 32'(ways_eff));
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (way_en[w] && vld[w] && rd.tag[w] == tag_reg)
            begin
                hit = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (way_en[w] && !vld[w])
            begin
                inv_found = 1'b1;
                inv_idx = WAY_W'(w);
            end
        end
        // oldest-stamp tree, lower way wins ties
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            lvl[MAX_WAYS-1+w] = '{en: way_en[w], stamp: rd.stamp[w], idx: WAY_W'(w)};
        end
        for (int n = MAX_WAYS - 2; n >= 0; n--)
        begin
            if (!lvl[2*n+2].en || (lvl[2*n+1].en && lvl[2*n+1].stamp <= lvl[2*n+2].stamp))
            begin
                lvl[n] = lvl[2*n+1];
            end
            else
            begin
                lvl[n] = lvl[2*n+2];
            end
        end
        lru_idx = lvl[0].idx;
    end

    always_comb
    begin
        fill      = !hit && (!kind_reg || walloc_reg);
        need_rand = fill && !inv_found && (policy_reg == RP_RANDOM);
        priority if (hit)
        begin
            victim = hit_idx;
        end
        else if (inv_found)
        begin
            victim = inv_idx;
        end
        else if (policy_reg == RP_RANDOM)
        begin
            victim = mrsp.rem;
        end
        else
        begin
            victim = lru_idx;
        end
        wb = fill && vld[victim] && dty[victim];
        added = '0;
        if (hit)
        begin
            if (kind_reg && wthru_reg)
            begin
                added = BASE_COST;
            end
        end
        else if (!kind_reg)
        begin
            added = penalty;
        end
        else
        begin
            added = ADD_W'((walloc_reg ? penalty : '0) + (wthru_reg ? BASE_COST : penalty));
        end
        if (wb)
        begin
            added = ADD_W'(added + penalty);
        end
        sum = {1'b0, total_reg} + (STAMP_W + 1)'(added);
        new_total = sum[STAMP_W] ? TOT_MAX : sum[STAMP_W-1:0];

        wr = rd;
        wr.valid = vld;
        wr.dirty = dty;
        if (hit)
        begin
            if (kind_reg && !wthru_reg)
            begin
                wr.dirty[hit_idx] = 1'b1;
            end
            if (policy_reg != RP_FIFO && policy_reg != RP_RANDOM)
            begin
                wr.stamp[hit_idx] = new_total;
            end
        end
        else if (fill)
        begin
            wr.valid[victim] = 1'b1;
            wr.dirty[victim] = kind_reg && !wthru_reg;
            wr.tag[victim]   = tag_reg;
            wr.stamp[victim] = new_total;
        end

        out_free = !out_valid_reg || rsp.ready;
        commit   = out_free && ((state_reg == ST_LOOK && !need_rand) ||
                                (state_reg == ST_MODW && mrsp.done));
        we       = commit;
    end

    assign mreq.start    = (state_reg == ST_LOOK) && need_rand;
    assign mreq.dividend = lfsr_next(lfsr_reg);
    assign mreq.divisor  = ways_eff;

    sacm_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign req.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sib_cfg_reg  <= '0;
            ways_cfg_reg <= 4'd1;
            bs_cfg_reg   <= 4'd2;
            walloc_reg   <= 1'b0;
            wthru_reg    <= 1'b0;
            policy_reg   <= RP_LRU;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SET_BITS: sib_cfg_reg  <= cfg_data;
                CFG_WAYS:     ways_cfg_reg <= cfg_data;
                CFG_BLOCK:    bs_cfg_reg   <= cfg_data;
                CFG_WALLOC:   walloc_reg   <= cfg_data[0];
                CFG_WTHROUGH: wthru_reg    <= cfg_data[0];
                CFG_POLICY:   policy_reg   <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_init_reg  <= '0;
            lfsr_reg      <= LFSR_SEED;
            total_reg     <= '0;
            lh_reg        <= '0;
            lm_reg        <= '0;
            sh_reg        <= '0;
            sm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        kind_reg  <= req.kind;
                        tag_reg   <= tag_in;
                        set_reg   <= set_in;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (need_rand)
                    begin
                        lfsr_reg  <= lfsr_next(lfsr_reg);
                        state_reg <= ST_MODW;
                    end
                    else if (commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MODW:
                begin
                    if (commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (commit)
            begin
                row_init_reg[set_reg] <= 1'b1;
                total_reg     <= new_total;
                out_valid_reg <= 1'b1;
                out_hit_reg   <= hit;
                out_wb_reg    <= wb;
                out_added_reg <= added;
                unique case ({kind_reg, hit})
                    2'b01:   if (lh_reg != CNT_MAX) lh_reg <= lh_reg + 1'b1;
                    2'b00:   if (lm_reg != CNT_MAX) lm_reg <= lm_reg + 1'b1;
                    2'b11:   if (sh_reg != CNT_MAX) sh_reg <= sh_reg + 1'b1;
                    default: if (sm_reg != CNT_MAX) sm_reg <= sm_reg + 1'b1;
                endcase
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.wrote_back   = out_wb_reg;
    assign rsp.cycles_added = out_added_reg;
    assign rsp.total_cycles = total_reg;
    assign rsp.load_hits    = lh_reg;
    assign rsp.load_misses  = lm_reg;
    assign rsp.store_hits   = sh_reg;
    assign rsp.store_misses = sm_reg;

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> total_reg >= $past(total_reg))
        else $error("cycle total decreased");

    a_load_hit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && hit && !kind_reg) |-> added == '0)
        else $error("load hit charged cycles");

    a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.wrote_back))
        else $error("write-back reported on a hit");

    a_rand_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODW && mrsp.done) |-> {1'b0, victim} < ways_eff)
        else $error("random victim outside the ways in use");

endmodule

FILE: hdl/sacm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module sacm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/sacm_mod.sv
// Bit-serial remainder unit: LFSR value modulo way count, one bit per cycle.
// Depends on sacm_pkg.
module sacm_mod import sacm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);
    localparam int STEP_W = $clog2(LFSR_W + 1);

    logic [LFSR_W-1:0] shift_reg;
    logic [WCNT_W-1:0] div_reg;
    logic [WCNT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WCNT_W:0]   trial;

    always_comb
    begin
        trial = {rem_reg, shift_reg[LFSR_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = WCNT_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[WCNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            shift_reg <= req.dividend;
            div_reg   <= req.divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[LFSR_W-2:0], 1'b0};
            step_reg  <= STEP_W'(step_reg + 1'b1);
            if (step_reg == STEP_W'(LFSR_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[WAY_W-1:0];
endmodule
